/* sv/bew_pkg.sv */
// Shared types and constants for the Bresenham edge walker.
// Used by bew_ctrl, bew_dp and bresenham_edge_walker; depends on nothing.
`default_nettype none

package bew_pkg;

  // Request kinds carried on s_tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP_A,
    ST_SETUP_B,
    ST_STEP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the input request payload
    logic setup_a;  // order endpoints, form deltas
    logic setup_b;  // pick the major axis, form the error terms
    logic iter;     // one Bresenham iteration
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;     // the current iteration produces a result
  } stat_t;

endpackage

`default_nettype wire

/* sv/bew_ctrl.sv */
// Controller state machine for the Bresenham edge walker.
// Depends on bew_pkg; drives the handshakes and the datapath commands.
`default_nettype none

module bew_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic           s_tuser,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  input  wire bew_pkg::stat_t stat,
  output bew_pkg::ctrl_t      ctrl
);

  bew_pkg::state_t state, state_next;
  logic out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bew_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    s_tready   = 1'b0;
    case (state)
      bew_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.latch = 1'b1;
          state_next = (s_tuser == bew_pkg::CMD_LOAD) ? bew_pkg::ST_SETUP_A
                                                      : bew_pkg::ST_STEP;
        end
      end
      bew_pkg::ST_SETUP_A: begin
        ctrl.setup_a = 1'b1;
        state_next   = bew_pkg::ST_SETUP_B;
      end
      bew_pkg::ST_SETUP_B: begin
        ctrl.setup_b = 1'b1;
        state_next   = bew_pkg::ST_IDLE;
      end
      bew_pkg::ST_STEP: begin
        // Iterate only when the output register can take a result.
        if (!out_valid || m_tready) begin
          ctrl.iter = 1'b1;
          if (stat.emit) begin
            state_next = bew_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = bew_pkg::ST_IDLE;
      end
    endcase

    if (ctrl.iter && stat.emit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

/* sv/bew_dp.sv */
// Datapath of the Bresenham edge walker: edge set-up, error terms,
// one walk iteration and the result register. Depends on bew_pkg.
`default_nettype none

module bew_dp #(
  parameter int COORD_BITS = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bew_pkg::ctrl_t        ctrl,
  output bew_pkg::stat_t             stat,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  output logic [COORD_BITS-1:0]      edge_x,
  output logic [COORD_BITS-1:0]      row_offset,
  output logic                       last,
  output logic                       exhausted
);

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  // Captured request payload.
  logic [CB-1:0] sx, sy, ex, ey;

  // Walker state.
  logic [CB-1:0]        cur_x, stop_x;
  logic signed [EW-1:0] err_term, err_keep_inc, err_step_inc;
  logic [CB-1:0]        row_count, rows_total;
  logic                 step_dir_neg, is_x_major, run_done;
  logic signed [CB:0]   dx_signed;

  // Set-up, first step.
  logic               swap;
  logic [CB-1:0]      ta_x, ta_y, tb_x, tb_y;
  logic signed [CB:0] dxs_c, dys_c;

  assign swap  = $signed(sy) > $signed(ey);
  assign ta_x  = swap ? ex : sx;
  assign ta_y  = swap ? ey : sy;
  assign tb_x  = swap ? sx : ex;
  assign tb_y  = swap ? sy : ey;
  assign dxs_c = $signed({tb_x[CB-1], tb_x}) - $signed({ta_x[CB-1], ta_x});
  assign dys_c = $signed({tb_y[CB-1], tb_y}) - $signed({ta_y[CB-1], ta_y});

  // Set-up, second step.
  logic [CB:0]          dx_mag;
  logic [CB-1:0]        dx;
  logic signed [EW-1:0] dx_e, dy_e, dx2, dy2;
  logic                 xmaj_c;

  assign dx_mag = dx_signed[CB] ? (CB+1)'(0 - dx_signed) : dx_signed;
  assign dx     = dx_mag[CB-1:0];
  assign dx_e   = $signed({3'b000, dx});
  assign dy_e   = $signed({3'b000, rows_total});
  assign dx2    = $signed({dx_e[EW-2:0], 1'b0});
  assign dy2    = $signed({dy_e[EW-2:0], 1'b0});
  assign xmaj_c = dx > rows_total;

  // One walk iteration.
  logic [CB-1:0]        x_moved;
  logic                 adv;
  logic                 row_lt;
  logic                 emit;
  logic [CB-1:0]        res_x, res_row;
  logic                 res_last, res_exh;
  logic [CB-1:0]        cur_x_next, row_count_next;
  logic signed [EW-1:0] err_term_next;
  logic                 run_done_next;

  assign x_moved = step_dir_neg ? cur_x - CB'(1) : cur_x + CB'(1);
  assign adv     = !err_term[EW-1];
  assign row_lt  = row_count < rows_total;

  always_comb begin
    emit           = 1'b1;
    res_x          = '0;
    res_row        = '0;
    res_last       = 1'b0;
    res_exh        = 1'b0;
    cur_x_next     = cur_x;
    row_count_next = row_count;
    err_term_next  = err_term;
    run_done_next  = run_done;
    if (run_done) begin
      res_exh = 1'b1;
    end else if (is_x_major) begin
      if (cur_x == stop_x) begin
        res_x         = stop_x;
        res_row       = row_count;
        res_last      = 1'b1;
        run_done_next = 1'b1;
      end else begin
        // The row reports the x visited just before the row advances.
        emit          = adv;
        res_x         = cur_x;
        res_row       = row_count;
        cur_x_next    = x_moved;
        err_term_next = err_term + (adv ? err_step_inc : err_keep_inc);
        if (adv && row_lt) begin
          row_count_next = row_count + CB'(1);
        end
      end
    end else begin
      res_x   = cur_x;
      res_row = row_count;
      if (!row_lt) begin
        res_last      = 1'b1;
        run_done_next = 1'b1;
      end else begin
        row_count_next = row_count + CB'(1);
        if (err_term[EW-1]) begin
          err_term_next = err_term + err_keep_inc;
        end else begin
          cur_x_next    = x_moved;
          err_term_next = err_term + err_step_inc;
        end
      end
    end
  end

  assign stat.emit = emit;

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      sx <= in_start_x;
      sy <= in_start_y;
      ex <= in_end_x;
      ey <= in_end_y;
    end
    if (ctrl.iter && emit) begin
      edge_x     <= res_x;
      row_offset <= res_row;
      last       <= res_last;
      exhausted  <= res_exh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      stop_x       <= '0;
      err_term     <= '0;
      err_keep_inc <= '0;
      err_step_inc <= '0;
      row_count    <= '0;
      rows_total   <= '0;
      step_dir_neg <= 1'b0;
      is_x_major   <= 1'b0;
      run_done     <= 1'b1;
      dx_signed    <= '0;
    end else if (ctrl.setup_a) begin
      cur_x        <= ta_x;
      stop_x       <= tb_x;
      dx_signed    <= dxs_c;
      rows_total   <= dys_c[CB-1:0];
      row_count    <= '0;
      // Equal x endpoints count as a negative direction.
      step_dir_neg <= dxs_c[CB] || (dxs_c == '0);
    end else if (ctrl.setup_b) begin
      is_x_major <= xmaj_c;
      run_done   <= 1'b0;
      if (xmaj_c) begin
        err_keep_inc <= dy2;
        err_step_inc <= dy2 - dx2;
        err_term     <= dy2 - dx_e;
      end else begin
        err_keep_inc <= dx2;
        err_step_inc <= dx2 - dy2;
        err_term     <= dx2 - dy_e;
      end
    end else if (ctrl.iter) begin
      cur_x     <= cur_x_next;
      row_count <= row_count_next;
      err_term  <= err_term_next;
      run_done  <= run_done_next;
    end
  end

endmodule

`default_nettype wire

/* sv/bresenham_edge_walker.sv */
// Top level of the Bresenham edge walker: joins bew_ctrl and bew_dp and
// packs the stream payloads. Depends on bew_pkg, bew_ctrl and bew_dp.
//
//   channel   direction  payload
//   s_*       in         tuser: cmd; tdata: start_x, start_y, end_x, end_y
//   m_*       out        tuser: exhausted; tlast: last; tdata: edge_x, row_offset
//
// A load request goes through capture, endpoint ordering and error terms.
// A step request is captured and then runs one iteration for a y-major
// edge, or one iteration per x pixel walked up to the next row change
// for an x-major edge; the controller iterates until the datapath emits.
// One request is worked on at a time; a waiting result sits in the output
// register while a load request is taken; a step request's iteration waits for it.
// Reset is synchronous and leaves no edge loaded; no clearing pass is needed.
`default_nettype none

module bresenham_edge_walker #(
  parameter int COORD_BITS = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata from bit 0: start_x, start_y, end_x, end_y, zero fill
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // s_tuser: cmd
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata from bit 0: edge_x, row_offset, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  output logic                       m_tlast,
  // m_tuser: exhausted
  output logic                       m_tuser
);

  localparam int CB    = COORD_BITS;
  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  bew_pkg::ctrl_t ctrl;
  bew_pkg::stat_t stat;
  logic [CB-1:0]  edge_x, row_offset;

  bew_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  bew_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_start_x (s_tdata[CB-1:0]),
    .in_start_y (s_tdata[2*CB-1:CB]),
    .in_end_x   (s_tdata[3*CB-1:2*CB]),
    .in_end_y   (s_tdata[4*CB-1:3*CB]),
    .edge_x     (edge_x),
    .row_offset (row_offset),
    .last       (m_tlast),
    .exhausted  (m_tuser)
  );

  assign m_tdata = OUT_W'({row_offset, edge_x});

  // An iteration that emits always fills the output register.
  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    (ctrl.iter && stat.emit) |=> m_tvalid)
    else $error("emitted result did not reach the output register");

  // An exhausted result carries zero fields and no last flag.
  a_exh_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (edge_x == '0 && row_offset == '0 && !m_tlast))
    else $error("exhausted result with nonzero fields");

  // No iteration or set-up step runs while a new request can be taken.
  a_no_iter_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(ctrl.iter || ctrl.setup_a || ctrl.setup_b))
    else $error("datapath busy while ready for a request");

endmodule

`default_nettype wire
